// ----- rtl/hdlcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcd_pkg
// Shared types, constants and the CRC-16/X.25 byte fold for the HDLC
// bit deframer.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int BYTE_CNT_W      = $clog2(MAX_FRAME_BYTES);
    localparam int REL_W           = (BYTE_CNT_W > 9) ? BYTE_CNT_W : 9;

    localparam logic [7:0]  FLAG_PATTERN  = 8'h7e;
    localparam logic [7:0]  ABORT_MASK    = 8'h7f;
    localparam logic [7:0]  STUFF_MASK    = 8'h3f;
    localparam logic [7:0]  STUFF_PATTERN = 8'h3e;
    localparam logic [15:0] CRC_INIT      = 16'hffff;
    localparam logic [15:0] CRC_XOROUT    = 16'hffff;
    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [4:0]  MIN_LEN_RESET = 5'd6;
    localparam logic [REL_W-1:0] MAX_RELEASED = REL_W'(510);

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_SHORT    = 3'd1,
        ST_CRC      = 3'd2,
        ST_ABORT    = 3'd3,
        ST_OVERSIZE = 3'd4
    } t_status;

    typedef struct packed {
        logic       init;
        logic       fold;
        logic [7:0] data;
    } t_crc_ctl;

    typedef struct packed {
        logic       vld;
        t_kind      kind;
        logic [7:0] data_byte;
        t_status    status;
        logic [8:0] length;
    } t_result;

    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                  input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/hdlc_bit_deframer_crc_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_bit_deframer_crc_check
// HDLC receiver: flag search, abort and bit-stuffing removal, LSB-first byte
// assembly, two-byte FCS hold and CRC-16/X.25 check with end-of-frame status.
// ----------------------------------------------------------------------------
// One line bit is taken per beat and a new bit can be accepted every clock
// cycle unless the input stalls. Each bit passes an input register, the
// deframing logic (window compare, byte assembly, hold shift, one CRC byte
// fold) and the result register, which drives the outputs. The input stalls
// only while a result waits and a further bit is held in the input register.
// At most one result beat follows each bit: a released data byte or a frame
// status (good, short, CRC fail, abort, oversize) with the payload length.
// The minimum frame length may be rewritten only while the block is idle.
// ----------------------------------------------------------------------------
module hdlc_bit_deframer_crc_check (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_line_bit,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [4:0] i_cfg_wr_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_kind,
    output logic [7:0]      o_data_byte,
    output logic [2:0]      o_frame_status,
    output logic [8:0]      o_frame_len
);
    import hdlcd_pkg::*;

    logic                  r_in_vld;
    logic                  r_in_bit;
    logic [7:0]            r_win;
    logic                  r_open;
    logic [2:0]            r_bit_cnt;
    logic [7:0]            r_asm;
    logic [BYTE_CNT_W-1:0] r_byte_cnt;
    logic [7:0]            r_held0;
    logic [7:0]            r_held1;
    logic [4:0]            r_min_len;

    logic [7:0]            n_win;
    logic                  n_open;
    logic [2:0]            n_bit_cnt;
    logic [7:0]            n_asm;
    logic [BYTE_CNT_W-1:0] n_byte_cnt;
    logic [7:0]            n_held0;
    logic [7:0]            n_held1;

    logic                  advance;
    logic                  accept;
    logic [15:0]           crc;
    logic [15:0]           fcs;
    logic [REL_W-1:0]      cnt_ext;
    logic [REL_W-1:0]      released;
    logic                  too_short;
    t_crc_ctl              c_crc_ctl;
    t_crc_ctl              crc_ctl;
    t_result               c_res;
    t_result               out_res;

    assign advance = r_in_vld && (!o_valid || !i_stall);
    assign o_stall = r_in_vld && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_bit <= i_line_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_len <= i_cfg_wr_data;
        end
    end

    assign cnt_ext   = REL_W'(r_byte_cnt);
    assign fcs       = crc ^ CRC_XOROUT;
    assign too_short = (cnt_ext < REL_W'(2)) || (cnt_ext < REL_W'(r_min_len));

    always_comb begin
        if (cnt_ext < REL_W'(2)) begin
            released = '0;
        end else if ((cnt_ext - REL_W'(2)) > MAX_RELEASED) begin
            released = MAX_RELEASED;
        end else begin
            released = cnt_ext - REL_W'(2);
        end
    end

    always_comb begin
        n_win      = {r_win[6:0], r_in_bit};
        n_open     = r_open;
        n_bit_cnt  = r_bit_cnt;
        n_asm      = r_asm;
        n_byte_cnt = r_byte_cnt;
        n_held0    = r_held0;
        n_held1    = r_held1;
        c_crc_ctl  = '0;
        c_res      = '0;
        c_res.kind   = KIND_DATA;
        c_res.status = ST_GOOD;

        if (n_win == FLAG_PATTERN) begin
            if (!r_open) begin
                n_open         = 1'b1;
                n_bit_cnt      = '0;
                n_byte_cnt     = '0;
                c_crc_ctl.init = 1'b1;
            end else begin
                n_open       = 1'b0;
                c_res.vld    = 1'b1;
                c_res.kind   = KIND_STATUS;
                c_res.length = released[8:0];
                if (too_short) begin
                    c_res.status = ST_SHORT;
                end else if (r_held0 != fcs[7:0] || r_held1 != fcs[15:8]) begin
                    c_res.status = ST_CRC;
                end else begin
                    c_res.status = ST_GOOD;
                end
            end
        end else if (r_open) begin
            if ((n_win & ABORT_MASK) == ABORT_MASK) begin
                n_open       = 1'b0;
                c_res.vld    = 1'b1;
                c_res.kind   = KIND_STATUS;
                c_res.status = ST_ABORT;
                c_res.length = released[8:0];
            end else if ((n_win & STUFF_MASK) != STUFF_PATTERN) begin
                n_asm     = {r_in_bit, r_asm[7:1]};
                n_bit_cnt = r_bit_cnt + 3'd1;
                if (n_bit_cnt == 3'd0) begin
                    if (r_byte_cnt >= BYTE_CNT_W'(MAX_FRAME_BYTES - 1)) begin
                        n_open       = 1'b0;
                        c_res.vld    = 1'b1;
                        c_res.kind   = KIND_STATUS;
                        c_res.status = ST_OVERSIZE;
                        c_res.length = released[8:0];
                    end else if (cnt_ext >= REL_W'(2)) begin
                        n_held0         = r_held1;
                        n_held1         = n_asm;
                        n_byte_cnt      = r_byte_cnt + BYTE_CNT_W'(1);
                        c_crc_ctl.fold  = 1'b1;
                        c_crc_ctl.data  = r_held0;
                        c_res.vld       = 1'b1;
                        c_res.kind      = KIND_DATA;
                        c_res.data_byte = r_held0;
                    end else begin
                        if (r_byte_cnt[0]) begin
                            n_held1 = n_asm;
                        end else begin
                            n_held0 = n_asm;
                        end
                        n_byte_cnt = r_byte_cnt + BYTE_CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_open     <= 1'b0;
            r_bit_cnt  <= '0;
            r_asm      <= '0;
            r_byte_cnt <= '0;
        end else if (advance) begin
            r_win      <= n_win;
            r_open     <= n_open;
            r_bit_cnt  <= n_bit_cnt;
            r_asm      <= n_asm;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

    assign crc_ctl = advance ? c_crc_ctl : '0;

    hdlcd_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    hdlcd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (c_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_frame_status = out_res.status;
    assign o_frame_len    = out_res.length;

endmodule
`default_nettype wire

// ----- rtl/hdlcd_crc16.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcd_crc16
// CRC-16/X.25 accumulator: preset on frame open, one byte folded per fold request.
// ----------------------------------------------------------------------------
module hdlcd_crc16 (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire hdlcd_pkg::t_crc_ctl i_ctl,
    output logic [15:0]              o_crc
);
    import hdlcd_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.fold) begin
            n_crc = crc_fold_byte(r_crc, i_ctl.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule
`default_nettype wire

// ----- rtl/hdlcd_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdlcd_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module hdlcd_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire hdlcd_pkg::t_result i_res,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output hdlcd_pkg::t_result      o_res
);
    import hdlcd_pkg::*;

    logic    r_vld;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_res.vld;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// ----- dv/hdlc_bit_deframer_crc_check_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdlc_bit_deframer_crc_check_test
// Self-checking bench for the HDLC bit deframer. Line bits are built from
// stuffed frames carrying a real or damaged CRC-16/X.25 FCS, aborts, stray
// bits and oversize frames. A bit-level deframer inside the bench predicts
// every data and status beat, and each beat the block delivers is compared
// field by field. Sender gaps and receiver stalls vary by phase, and the
// minimum frame length is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module hdlc_bit_deframer_crc_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlcd_pkg::*;

    localparam logic [7:0]  HDLC_FLAG    = 8'h7e;
    localparam logic [7:0]  SEVEN_ONES   = 8'h7f;
    localparam logic [7:0]  STUFF_SEL    = 8'h3f;
    localparam logic [7:0]  STUFF_SEEN   = 8'h3e;
    localparam logic [15:0] X25_SEED     = 16'hffff;
    localparam logic [15:0] X25_POLY     = 16'h8408;
    localparam int          MAX_RELEASE  = 510;
    localparam int          LIMIT_CYCLES = 600000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          PRINT_CAP    = 50;

    typedef enum logic [1:0] {
        FCS_NONE,
        FCS_GOOD,
        FCS_BAD
    } t_fcs_mode;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        t_status    status;
        logic [8:0] length;
    } t_rx_beat;

    typedef logic [7:0] t_byte_q[$];

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_line_bit = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [4:0] i_cfg_wr_data = 5'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_kind;
    logic [7:0] o_data_byte;
    logic [2:0] o_frame_status;
    logic [8:0] o_frame_len;

    hdlc_bit_deframer_crc_check i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_line_bit     (i_line_bit),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_status (o_frame_status),
        .o_frame_len    (o_frame_len)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // deframer state as the bench sees it
    logic [7:0]  win = 8'h00;
    logic        in_frame = 1'b0;
    logic [2:0]  nbits = 3'd0;
    logic [7:0]  shreg = 8'h00;
    int          nbytes = 0;
    logic [7:0]  held [0:1] = '{8'h00, 8'h00};
    logic [15:0] crc = X25_SEED;
    logic [4:0]  min_len = 5'd6;

    t_rx_beat    pending_beats[$];

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          ones_run = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned bits_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned data_seen = 0;
    int unsigned status_seen [0:4] = '{0, 0, 0, 0, 0};

    function automatic logic [15:0] crc_x25(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = c_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ X25_POLY;
            end
        end
        return c;
    endfunction

    function automatic void push_status(input t_status st);
        t_rx_beat e;
        int       rel;
        rel = (nbytes >= 2) ? nbytes - 2 : 0;
        if (rel > MAX_RELEASE) begin
            rel = MAX_RELEASE;
        end
        e.kind   = KIND_STATUS;
        e.data   = 8'h00;
        e.status = st;
        e.length = 9'(rel);
        pending_beats.push_back(e);
    endfunction

    function automatic void deframe_bit(input logic b);
        t_rx_beat    e;
        logic [7:0]  gone;
        logic [15:0] fcs;
        win = {win[6:0], b};
        if (win == HDLC_FLAG) begin
            if (!in_frame) begin
                in_frame = 1'b1;
                nbits    = 3'd0;
                nbytes   = 0;
                crc      = X25_SEED;
                return;
            end
            in_frame = 1'b0;
            fcs = ~crc;
            if (nbytes < 2 || nbytes < int'(min_len)) begin
                push_status(ST_SHORT);
            end else if (held[0] != fcs[7:0] || held[1] != fcs[15:8]) begin
                push_status(ST_CRC);
            end else begin
                push_status(ST_GOOD);
            end
            return;
        end
        if (!in_frame) begin
            return;
        end
        if ((win & SEVEN_ONES) == SEVEN_ONES) begin
            in_frame = 1'b0;
            push_status(ST_ABORT);
            return;
        end
        if ((win & STUFF_SEL) == STUFF_SEEN) begin
            return;
        end
        shreg = {b, shreg[7:1]};
        nbits = nbits + 3'd1;
        if (nbits != 3'd0) begin
            return;
        end
        if (nbytes + 1 >= MAX_FRAME_BYTES) begin
            in_frame = 1'b0;
            push_status(ST_OVERSIZE);
            return;
        end
        if (nbytes >= 2) begin
            gone    = held[0];
            held[0] = held[1];
            held[1] = shreg;
            nbytes++;
            crc = crc_x25(crc, gone);
            e.kind   = KIND_DATA;
            e.data   = gone;
            e.status = ST_GOOD;
            e.length = 9'd0;
            pending_beats.push_back(e);
        end else begin
            held[nbytes % 2] = shreg;
            nbytes++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("%0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                     pending_beats.size());
            $display("hdlc_bit_deframer_crc_check: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_rx_beat want;
        i_stall <= ($urandom_range(99) < stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d data %02h status %0d len %0d",
                                          o_kind, o_data_byte, o_frame_status,
                                          o_frame_len));
            end else begin
                want = pending_beats.pop_front();
                if (o_kind !== want.kind) begin
                    report_mismatch($sformatf("kind: expected %0d got %0d", want.kind, o_kind));
                end
                if (o_data_byte !== want.data) begin
                    report_mismatch($sformatf("data_byte: expected %02h got %02h",
                                              want.data, o_data_byte));
                end
                if (o_frame_status !== want.status) begin
                    report_mismatch($sformatf("frame_status: expected %0d got %0d",
                                              want.status, o_frame_status));
                end
                if (o_frame_len !== want.length) begin
                    report_mismatch($sformatf("frame_len: expected %0d got %0d",
                                              want.length, o_frame_len));
                end
                if (want.kind == KIND_STATUS) begin
                    status_seen[int'(want.status)]++;
                end else begin
                    data_seen++;
                end
            end
        end
    end

    task automatic send_bit(input logic b);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_line_bit <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        deframe_bit(b);
        bits_sent++;
    endtask

    // insert a zero after five ones
    task automatic send_data_bit(input logic b);
        send_bit(b);
        ones_run = b ? ones_run + 1 : 0;
        if (ones_run == 5) begin
            send_bit(1'b0);
            ones_run = 0;
        end
    endtask

    task automatic send_byte(input logic [7:0] v);
        for (int i = 0; i < 8; i++) begin
            send_data_bit(v[i]);
        end
    endtask

    task automatic send_flag();
        for (int i = 0; i < 8; i++) begin
            send_bit(HDLC_FLAG[i]);
        end
        ones_run = 0;
    endtask

    task automatic send_ones(input int n);
        repeat (n) send_bit(1'b1);
        ones_run = 0;
    endtask

    function automatic t_byte_q random_body(input int n);
        t_byte_q q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic send_frame(input t_byte_q body, input t_fcs_mode mode, input int tail);
        logic [15:0] fcs;
        fcs = X25_SEED;
        foreach (body[i]) begin
            fcs = crc_x25(fcs, body[i]);
        end
        fcs = ~fcs;
        if (mode == FCS_BAD) begin
            fcs = fcs ^ (16'd1 << $urandom_range(15));
        end
        send_flag();
        foreach (body[i]) begin
            send_byte(body[i]);
        end
        if (mode != FCS_NONE) begin
            send_byte(fcs[7:0]);
            send_byte(fcs[15:8]);
        end
        repeat (tail) send_data_bit(1'($urandom));
        send_flag();
        frames_sent++;
    endtask

    task automatic send_aborted(input int n, input int tail, input int ones);
        send_flag();
        repeat (n) send_byte(8'($urandom));
        repeat (tail) send_data_bit(1'($urandom));
        send_ones(ones);
        frames_sent++;
    endtask

    task automatic send_gap();
        int n;
        n = $urandom_range(10);
        if ($urandom_range(3) == 0) begin
            repeat (n % 4) send_bit(1'b0);
        end else begin
            repeat (n) send_bit(1'b1);
        end
        ones_run = 0;
    endtask

    task automatic wait_all_delivered();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_min_length(input logic [4:0] v);
        wait_all_delivered();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        min_len = v;
    endtask

    task automatic set_traffic(input int sel);
        case (sel)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 57;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 57;
            end
            default: begin
                idle_pct  = 32;
                stall_pct = 32;
            end
        endcase
    endtask

    task automatic test_framing_basics();
        set_traffic(3);
        send_frame(random_body(0), FCS_NONE, 0);
        send_frame(random_body(1), FCS_NONE, 0);
        send_frame(random_body(4), FCS_GOOD, 0);
        send_frame(random_body(3), FCS_GOOD, 0);
        send_ones(9);
        send_frame(random_body(5), FCS_GOOD, 0);
    endtask

    task automatic test_data_patterns();
        t_byte_q body;
        body = '{8'h00, 8'hff, 8'h7e, 8'h7f, 8'hfe, 8'h3e, 8'hf8, 8'h1f, 8'hff, 8'h01};
        send_frame(body, FCS_GOOD, 0);
        body = '{8'hff, 8'hff, 8'hff, 8'hff};
        send_frame(body, FCS_GOOD, 0);
        body = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(body, FCS_GOOD, 0);
    endtask

    task automatic test_fcs_errors();
        send_frame(random_body(6), FCS_BAD, 0);
        send_frame(random_body(4), FCS_BAD, 0);
        send_frame(random_body(12), FCS_BAD, 0);
    endtask

    task automatic test_aborts();
        send_aborted(0, 0, 7);
        send_aborted(5, 3, 8);
        send_aborted(1, 0, 12);
        send_aborted(9, 7, 7);
    endtask

    task automatic test_partial_bytes();
        for (int t = 1; t < 8; t++) begin
            send_frame(random_body($urandom_range(6, 4)), FCS_GOOD, t);
        end
    endtask

    task automatic test_min_length_extremes();
        set_min_length(5'd0);
        send_frame(random_body(1), FCS_NONE, 0);
        send_frame(random_body(0), FCS_GOOD, 0);
        set_min_length(5'd1);
        send_frame(random_body(1), FCS_NONE, 0);
        send_frame(random_body(0), FCS_GOOD, 0);
        set_min_length(5'd31);
        send_frame(random_body(29), FCS_GOOD, 0);
        send_frame(random_body(28), FCS_GOOD, 0);
        set_min_length(5'd2);
        send_frame(random_body(0), FCS_GOOD, 0);
        set_min_length(5'd16);
        send_frame(random_body(14), FCS_GOOD, 0);
        send_frame(random_body(13), FCS_GOOD, 0);
    endtask

    task automatic test_oversize();
        set_traffic(0);
        send_flag();
        // the last byte overflows the frame; drop it and idle on ones
        repeat (MAX_FRAME_BYTES) send_byte(8'($urandom));
        send_ones(8);
        frames_sent++;
    endtask

    task automatic test_random_traffic();
        int unsigned phase_start;
        int          pick;
        int          n;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_min_length(5'd2);
                1: set_min_length(5'd16);
                2: set_min_length(5'd1);
                3: set_min_length(5'd31);
                4: set_min_length(5'($urandom_range(16, 2)));
                default: set_min_length(5'd0);
            endcase
            set_traffic(ph % 4);
            phase_start = bits_sent;
            while (bits_sent - phase_start < 300) begin
                pick = $urandom_range(99);
                n = ($urandom_range(99) < 5) ? $urandom_range(60, 30) : $urandom_range(12);
                if (pick < 50) begin
                    send_frame(random_body(n), FCS_GOOD, 0);
                end else if (pick < 65) begin
                    send_frame(random_body(n), FCS_BAD, 0);
                end else if (pick < 75) begin
                    send_frame(random_body(n), t_fcs_mode'($urandom_range(2, 1)),
                               $urandom_range(7, 1));
                end else if (pick < 85) begin
                    send_aborted(n, $urandom_range(7), $urandom_range(12, 7));
                end else if (pick < 92) begin
                    repeat ($urandom_range(40, 4)) send_bit(1'($urandom));
                    send_ones(8);
                end else begin
                    send_frame(random_body($urandom_range(3)), FCS_NONE, 0);
                end
                if ($urandom_range(9) == 0) begin
                    wait_all_delivered();
                end
                send_gap();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing_basics();
        test_data_patterns();
        test_fcs_errors();
        test_aborts();
        test_partial_bytes();
        test_min_length_extremes();
        test_oversize();
        test_random_traffic();
        wait_all_delivered();
        if (pending_beats.size() != 0) begin
            report_mismatch($sformatf("%0d expected beats never arrived", pending_beats.size()));
        end
        $display("covered %0d line bits in %0d frames, %0d data bytes checked",
                 bits_sent, frames_sent, data_seen);
        $display("frame ends: good %0d, short %0d, crc fail %0d, abort %0d, oversize %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0) begin
            $display("hdlc_bit_deframer_crc_check: match");
        end else begin
            $display("hdlc_bit_deframer_crc_check: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/hdlcd_pkg.sv
rtl/hdlcd_crc16.sv
rtl/hdlcd_out_reg.sv
rtl/hdlc_bit_deframer_crc_check.sv
dv/hdlc_bit_deframer_crc_check_test.sv
